// ----- design/rotary_encoder_button_qualifier_macros.svh -----
// Assertion macros shared by the rotary encoder button qualifier modules.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

`define REBQ_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define REBQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define REBQ_ASSERT(label, clk, rst, ante, cons, msg)

`define REBQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/rebq_pkg.sv -----
// Types, constants and the quadrature transition table of the encoder qualifier.
// No dependencies; used by every module of the block.
package rebq_pkg;

   localparam int HOLD_COUNT_BITS = 16;
   localparam int STABLE_BITS     = 11;
   localparam int LONG_BITS       = 16;
   localparam int CMP_BITS        = (HOLD_COUNT_BITS > LONG_BITS) ? HOLD_COUNT_BITS : LONG_BITS;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [STABLE_BITS-1:0]     STABLE_MAX = '1;
   localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX   = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_DIVIDER     = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION_INVERT = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS   = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_TICKS = 8'd3;

   localparam logic [4:0]           RESET_STEP_DIVIDER     = 5'd4;
   localparam logic                 RESET_DIRECTION_INVERT = 1'b0;
   localparam logic [9:0]           RESET_DEBOUNCE_TICKS   = 10'd50;
   localparam logic [LONG_BITS-1:0] RESET_LONG_PRESS_TICKS = 16'd1000;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_CLICK = 2'd1,
      EV_LONG  = 2'd2
   } rebq_event_type;

   typedef struct packed {
      logic [LONG_BITS-1:0] long_press_ticks;
      logic [9:0]           debounce_ticks;
      logic                 direction_invert;
      logic [4:0]           step_divider;
   } rebq_cfg_type;

   typedef struct packed {
      logic ms_tick;
      logic button_level;
      logic pin_b;
      logic pin_a;
   } rebq_sample_type;

   // Index is {previous A, previous B, new A, new B}.
   function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
      logic signed [1:0] dir;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: dir = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: dir = 2'sd1;
         default: dir = 2'sd0;
      endcase
      return dir;
   endfunction

endpackage

// ----- design/rebq_quad_decoder.sv -----
// Quadrature decoder: transition lookup, optional inversion and detent division.
// Depends on rebq_pkg.
module rebq_quad_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rebq_pkg::rebq_cfg_type cfg,
   input  logic                  pin_a,
   input  logic                  pin_b,
   output logic signed [1:0]     detent
);
   import rebq_pkg::*;

   logic [1:0]        prev_ab_ff;
   logic [1:0]        prev_ab_in;
   logic signed [4:0] rem_ff;
   logic signed [4:0] rem_in;
   logic signed [1:0] dir_raw;
   logic signed [1:0] dir;
   logic [4:0]        div;
   logic signed [6:0] div_s;
   logic signed [6:0] sum;

   always_comb begin
      prev_ab_in = {pin_a, pin_b};
      dir_raw    = quad_dir({prev_ab_ff, pin_a, pin_b});
      dir        = cfg.direction_invert ? -dir_raw : dir_raw;
      priority if (cfg.step_divider == 5'd0) begin
         div = 5'd1;
      end else if (cfg.step_divider > 5'd16) begin
         div = 5'd16;
      end else begin
         div = cfg.step_divider;
      end
      div_s  = $signed({2'b00, div});
      sum    = 7'(rem_ff) + 7'(dir);
      priority if (sum >= div_s) begin
         detent = 2'sd1;
         rem_in = 5'sd0;
      end else if (sum <= -div_s) begin
         detent = -2'sd1;
         rem_in = 5'sd0;
      end else begin
         detent = 2'sd0;
         rem_in = sum[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff <= 2'b11;
         rem_ff     <= 5'sd0;
      end else if (en) begin
         prev_ab_ff <= prev_ab_in;
         rem_ff     <= rem_in;
      end
   end

endmodule

// ----- design/rebq_button_qual.sv -----
// Button qualifier: debounce by stable tick count, click and long press events.
// Depends on rebq_pkg and the assertion macro header.
`include "rotary_encoder_button_qualifier_macros.svh"

module rebq_button_qual (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  rebq_pkg::rebq_cfg_type    cfg,
   input  rebq_pkg::rebq_sample_type sample,
   output rebq_pkg::rebq_event_type  event_code
);
   import rebq_pkg::*;

   logic                       prev_button_ff;
   logic [STABLE_BITS-1:0]     stable_ff;
   logic [STABLE_BITS-1:0]     stable_in;
   logic                       held_ff;
   logic                       held_in;
   logic                       long_fired_ff;
   logic                       long_fired_in;
   logic [HOLD_COUNT_BITS-1:0] held_count_ff;
   logic [HOLD_COUNT_BITS-1:0] held_count_in;

   always_comb begin
      stable_in = stable_ff;
      if (sample.ms_tick && stable_ff != STABLE_MAX) begin
         stable_in = stable_ff + 1'b1;
      end
      if (sample.button_level != prev_button_ff) begin
         stable_in = '0;
      end
      held_count_in = held_count_ff;
      if (sample.ms_tick && held_ff && held_count_ff != HOLD_MAX) begin
         held_count_in = held_count_ff + 1'b1;
      end
      held_in       = held_ff;
      long_fired_in = long_fired_ff;
      event_code    = EV_NONE;
      if (stable_in > {1'b0, cfg.debounce_ticks}) begin
         priority if (!sample.button_level && !held_ff) begin
            held_in       = 1'b1;
            held_count_in = '0;
            long_fired_in = 1'b0;
         end else if (sample.button_level && held_ff) begin
            held_in = 1'b0;
            if (!long_fired_ff) begin
               event_code = EV_CLICK;
            end
         end else begin
            held_in = held_ff;
         end
      end
      if (held_in && !long_fired_in &&
          CMP_BITS'(held_count_in) >= CMP_BITS'(cfg.long_press_ticks)) begin
         long_fired_in = 1'b1;
         event_code    = EV_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff <= 1'b1;
         stable_ff      <= '0;
         held_ff        <= 1'b0;
         long_fired_ff  <= 1'b0;
         held_count_ff  <= '0;
      end else if (en) begin
         prev_button_ff <= sample.button_level;
         stable_ff      <= stable_in;
         held_ff        <= held_in;
         long_fired_ff  <= long_fired_in;
         held_count_ff  <= held_count_in;
      end
   end

   `REBQ_ASSERT_NEXT(a_click_releases, clock, reset, en && event_code == EV_CLICK, !held_ff, "click without release")
   `REBQ_ASSERT_NEXT(a_long_marks, clock, reset, en && event_code == EV_LONG, held_ff && long_fired_ff, "long press not recorded")
   `REBQ_ASSERT_NEXT(a_idle_holds, clock, reset, !en, $stable(held_count_ff) && $stable(stable_ff), "counters moved without a beat")

endmodule

// ----- design/rotary_encoder_button_qualifier.sv -----
// Top level of the rotary encoder button qualifier: stream ports, registers, pipeline.
// Depends on rebq_pkg, rebq_quad_decoder, rebq_button_qual and the macro header.
//
//   channel   direction  handshake               payload
//   req_      in         req_tvalid/req_tready   req_tdata: pin samples
//   rsp_      out        rsp_tvalid/rsp_tready   rsp_tdata: detent and button event
//   csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// One beat is accepted per clock while rsp_ does not stall; a beat is held in the input register,
// passes the decode logic and its result is presented from the result register behind it.
// reset is synchronous and restores the CSR registers, the valid flags and all encoder and button state.
// A stalled rsp_ holds its beat while one more request waits in the input register.
// csr_ready is always high; writes take effect on the next clock.
`include "rotary_encoder_button_qualifier_macros.svh"

module rotary_encoder_button_qualifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] pin_a, [1] pin_b, [2] button_level, [3] ms_tick, [7:4] zero
   input  logic [7:0]                          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] detent_step (signed), [3:2] button_event, [7:4] zero
   output logic [7:0]                          rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rebq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rebq_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rebq_pkg::*;

   rebq_cfg_type      cfg_ff;
   rebq_cfg_type      cfg_in;
   logic              s1_valid_ff;
   rebq_sample_type   s1_sample_ff;
   logic              rsp_valid_ff;
   logic signed [1:0] rsp_detent_ff;
   rebq_event_type    rsp_event_ff;
   logic              advance;
   logic signed [1:0] detent;
   rebq_event_type    event_code;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_event_ff, rsp_detent_ff};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_DIVIDER:     cfg_in.step_divider     = csr_data[4:0];
            CSR_DIRECTION_INVERT: cfg_in.direction_invert = csr_data[0];
            CSR_DEBOUNCE_TICKS:   cfg_in.debounce_ticks   = csr_data[9:0];
            CSR_LONG_PRESS_TICKS: cfg_in.long_press_ticks = csr_data[LONG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_divider     <= RESET_STEP_DIVIDER;
         cfg_ff.direction_invert <= RESET_DIRECTION_INVERT;
         cfg_ff.debounce_ticks   <= RESET_DEBOUNCE_TICKS;
         cfg_ff.long_press_ticks <= RESET_LONG_PRESS_TICKS;
         s1_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_sample_ff <= req_tdata[3:0];
      end
      if (advance) begin
         rsp_detent_ff <= detent;
         rsp_event_ff  <= event_code;
      end
   end

   rebq_quad_decoder u_quad (
      .clock  (clock),
      .reset  (reset),
      .en     (advance),
      .cfg    (cfg_ff),
      .pin_a  (s1_sample_ff.pin_a),
      .pin_b  (s1_sample_ff.pin_b),
      .detent (detent)
   );

   rebq_button_qual u_button (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .cfg        (cfg_ff),
      .sample     (s1_sample_ff),
      .event_code (event_code)
   );

   `REBQ_ASSERT(a_rsp_from_s1, clock, reset, $rose(rsp_valid_ff), $past(s1_valid_ff), "result without a held request")
   `REBQ_ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, s1_valid_ff, "accepted beat lost")
   `REBQ_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_sample_ff), "waiting request dropped")

endmodule
